[rtl/svp_pkg.sv]
// Shared types and constants for the sample voice player.
package svp_pkg;

  // Request codes carried by an input item.
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_STOP  = 2'd3
  } req_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PITCH_STEP    = 3'd0,
    REG_START_GAIN    = 3'd1,
    REG_LOOP_ENABLE   = 3'd2,
    REG_SAMPLE_FRAMES = 3'd3,
    REG_MASTER_GAIN   = 3'd4
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD0,
    ST_RD1,
    ST_MUL1,
    ST_SUM,
    ST_MULG,
    ST_RNDX,
    ST_MULM,
    ST_FIN,
    ST_OUT
  } state_t;

  // Fixed field widths.
  localparam int PITCH_W   = 24;
  localparam int GAIN_W    = 16;
  localparam int FRAMES_W  = 17;
  localparam int SAMPLE_W  = 16;
  localparam int INDEX_W   = 16;
  localparam int FADE_W    = 20;
  localparam int POS_W     = 32;
  localparam int GAINACC_W = 32;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Constants of the playback arithmetic.
  localparam logic [PITCH_W-1:0]  UNITY_STEP   = 24'h010000;
  localparam logic [FRAMES_W-1:0] MAX_FRAMES   = 17'h10000;
  localparam logic [PITCH_W-1:0]  PITCH_RST    = 24'h010000;
  localparam logic [GAIN_W-1:0]   GAIN_RST     = 16'h4000;

  // Operand pair for the shared multiplier.
  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_op_t;

endpackage

[rtl/svp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module svp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

[rtl/svp_mul.sv]
// Shared signed multiplier with a registered product.
module svp_mul (
  input  logic                                clk,
  input  svp_pkg::mul_op_t                    op,
  output logic signed [svp_pkg::MUL_P_W-1:0]  prod_r
);

  logic signed [svp_pkg::MUL_A_W-1:0] a_s;
  logic signed [svp_pkg::MUL_B_W-1:0] b_s;

  assign a_s = op.a;
  assign b_s = op.b;

  // One product per cycle, registered before any further use.
  always_ff @(posedge clk) begin
    prod_r <= svp_pkg::MUL_P_W'(a_s) * svp_pkg::MUL_P_W'(b_s);
  end

endmodule

[rtl/svp_div.sv]
// Restoring divider for the fade ramp step, one quotient bit per cycle.
module svp_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [svp_pkg::GAINACC_W-1:0]     dividend,
  input  logic [svp_pkg::FADE_W-1:0]        divisor,
  output logic                              busy,
  output logic [svp_pkg::GAINACC_W-1:0]     quotient
);

  localparam int NUM_W = svp_pkg::GAINACC_W;
  localparam int DEN_W = svp_pkg::FADE_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Partial remainder with the next dividend bit shifted in.
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

endmodule

[rtl/sample_voice_player_core.sv]
// Top level of the single-voice sample player with linear interpolation.
//
// Load items fill the sample store, start items arm the voice, tick items
// produce one output frame each and stop items set up a fade to silence.
// Every item gives exactly one result item. The block works on one item at a
// time: a load, a start, an idle tick or a zero-length stop passes straight
// to the output state; a tick on a playing voice that reads a frame runs
// through the two store reads and the four passes through the single
// shared multiplier (two interpolation products, voice gain and master gain),
// each followed by a rounding or summing step; a stop with a non-zero fade
// waits on the 32-step restoring divider that works out the per-tick gain
// decrement. A finished result waits in the output register, so the next
// item is taken while it is still stalled.
// The sample store needs no clearing after reset.
module sample_voice_player_core #(
  parameter int STORE_DEPTH = 65536
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_req_type,
  input  logic [svp_pkg::INDEX_W-1:0]           in_sample_index,
  input  logic signed [svp_pkg::SAMPLE_W-1:0]   in_sample_value,
  input  logic [svp_pkg::FADE_W-1:0]            in_fade_steps,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [svp_pkg::SAMPLE_W-1:0]   out_audio_out,
  output logic                                  out_voice_active,
  // Configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [svp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [svp_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int EW = ((AW > svp_pkg::FRAMES_W) ? AW : svp_pkg::FRAMES_W) + 1;
  localparam int PW = svp_pkg::MUL_P_W;
  localparam int AcW = svp_pkg::MUL_A_W;
  localparam logic signed [PW-1:0] HALF16 = PW'(32768);
  localparam logic signed [PW-1:0] HALF28 = PW'(134217728);
  localparam logic signed [PW-1:0] Y_MAX  = PW'(32767);
  localparam logic signed [PW-1:0] Y_MIN  = -PW'(32768);

  svp_pkg::state_t state_r, state_nxt;
  svp_pkg::req_t   req;

  // Configuration registers.
  logic [svp_pkg::PITCH_W-1:0]  pitch_r;
  logic [svp_pkg::GAIN_W-1:0]   start_gain_r;
  logic                         loop_r;
  logic [svp_pkg::FRAMES_W-1:0] frames_r;
  logic [svp_pkg::GAIN_W-1:0]   master_r;

  // Voice state.
  logic [svp_pkg::POS_W-1:0]     pos_r;
  logic [svp_pkg::GAINACC_W-1:0] gain_r;
  logic [svp_pkg::GAINACC_W-1:0] incr_r;
  logic [svp_pkg::FADE_W-1:0]    ramp_r;
  logic [svp_pkg::FADE_W-1:0]    fade_r;
  logic                          playing_r;

  // Per-tick working registers.
  logic [15:0]                   base_r;
  logic [15:0]                   frac_r;
  logic                          direct_r;
  logic                          fired_r;
  logic                          more_r;
  logic [svp_pkg::POS_W-1:0]     newpos_r;
  logic                          rng0_r;
  logic                          rng1_r;
  logic signed [AcW-1:0]         acc_r;
  logic signed [svp_pkg::SAMPLE_W-1:0] res_r;

  // Output register.
  logic                                out_valid_r;
  logic signed [svp_pkg::SAMPLE_W-1:0] audio_r;
  logic                                active_r;

  // Internal connections.
  logic                          in_acc;
  logic                          out_free;
  logic                          div_start;
  logic                          div_busy;
  logic [svp_pkg::GAINACC_W-1:0] div_quo;
  svp_pkg::mul_op_t              mul_op;
  logic signed [PW-1:0]          prod_r;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [AW-1:0]                 ram_raddr;
  logic [svp_pkg::SAMPLE_W-1:0]  ram_rdata;
  logic [EW-1:0]                 wr_ext;
  logic [EW-1:0]                 rd_ext;
  logic [svp_pkg::FRAMES_W-1:0]  rd_idx;
  logic                          rd_in_range;
  logic signed [AcW-1:0]         s_ext;

  // Tick decision terms.
  logic [svp_pkg::FRAMES_W-1:0]  frames_eff;
  logic [svp_pkg::FRAMES_W-1:0]  frames_m1;
  logic [svp_pkg::POS_W-1:0]     dmax;
  logic                          direct_now;
  logic [svp_pkg::POS_W:0]       pos_sum;
  logic                          fire_now;
  logic                          more_now;
  logic [svp_pkg::POS_W-1:0]     newpos_now;

  // Rounding and saturation terms.
  logic signed [PW-1:0]          sum16;
  logic signed [PW-1:0]          sh16;
  logic signed [PW-1:0]          sum28;
  logic signed [PW-1:0]          sh28;
  logic signed [svp_pkg::SAMPLE_W-1:0] y_sat;
  logic                          forced;
  logic                          go_on;

  assign req       = svp_pkg::req_t'(in_req_type);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_audio_out    = audio_r;
  assign out_voice_active = active_r;

  // Play window and position advance for the coming tick.
  assign frames_eff = (frames_r > svp_pkg::MAX_FRAMES) ? svp_pkg::MAX_FRAMES : frames_r;
  assign frames_m1  = frames_eff - 1'b1;
  assign dmax       = (frames_eff == '0) ? '0 : {frames_m1[15:0], 16'h0000};
  assign direct_now = (pitch_r == svp_pkg::UNITY_STEP);
  assign pos_sum    = {1'b0, pos_r} + (svp_pkg::POS_W + 1)'(pitch_r);
  assign fire_now   = direct_now ? ({1'b0, pos_r[31:16]} < frames_eff) : (pos_r < dmax);
  assign more_now   = direct_now ? (pos_sum[32:16] < frames_eff)
                                 : (pos_sum < {1'b0, dmax});
  assign newpos_now = pos_sum[svp_pkg::POS_W] ? '1 : pos_sum[svp_pkg::POS_W-1:0];

  // Store addressing with out-of-range detection.
  assign wr_ext      = EW'(in_sample_index);
  assign ram_waddr   = wr_ext[AW-1:0];
  assign rd_idx      = (state_r == svp_pkg::ST_RD1) ? ({1'b0, base_r} + 1'b1)
                                                    : {1'b0, base_r};
  assign rd_ext      = EW'(rd_idx);
  assign rd_in_range = (rd_ext < EW'(STORE_DEPTH));
  assign ram_raddr   = rd_ext[AW-1:0];
  assign s_ext       = AcW'($signed(ram_rdata));

  // Rounding of the voice-gain and master-gain products.
  assign sum16 = prod_r + HALF16;
  assign sh16  = sum16 >>> 16;
  assign sum28 = prod_r + HALF28;
  assign sh28  = sum28 >>> 28;

  always_comb begin
    if (sh28 > Y_MAX) begin
      y_sat = 16'sh7FFF;
    end else if (sh28 < Y_MIN) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = sh28[svp_pkg::SAMPLE_W-1:0];
    end
  end

  // End-of-tick decision.
  assign forced = (fade_r == svp_pkg::FADE_W'(1));
  assign go_on  = fired_r && more_r && !forced;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      svp_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (req)
            svp_pkg::REQ_TICK: begin
              if (!playing_r) begin
                state_nxt = svp_pkg::ST_OUT;
              end else if (fire_now) begin
                state_nxt = svp_pkg::ST_RD0;
              end else begin
                state_nxt = svp_pkg::ST_FIN;
              end
            end
            svp_pkg::REQ_STOP: begin
              state_nxt = (in_fade_steps == '0) ? svp_pkg::ST_OUT : svp_pkg::ST_DIV;
            end
            default: state_nxt = svp_pkg::ST_OUT;
          endcase
        end
      end
      svp_pkg::ST_DIV:  if (!div_busy) state_nxt = svp_pkg::ST_OUT;
      svp_pkg::ST_RD0:  state_nxt = svp_pkg::ST_RD1;
      svp_pkg::ST_RD1:  state_nxt = svp_pkg::ST_MUL1;
      svp_pkg::ST_MUL1: state_nxt = svp_pkg::ST_SUM;
      svp_pkg::ST_SUM:  state_nxt = svp_pkg::ST_MULG;
      svp_pkg::ST_MULG: state_nxt = svp_pkg::ST_RNDX;
      svp_pkg::ST_RNDX: state_nxt = svp_pkg::ST_MULM;
      svp_pkg::ST_MULM: state_nxt = svp_pkg::ST_FIN;
      svp_pkg::ST_FIN:  state_nxt = svp_pkg::ST_OUT;
      svp_pkg::ST_OUT:  if (out_free) state_nxt = svp_pkg::ST_IDLE;
      default:          state_nxt = svp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, store write, divider start, multiplier operands.
  always_comb begin
    in_stall  = (state_r != svp_pkg::ST_IDLE) || !rst_n;
    ram_we    = 1'b0;
    div_start = 1'b0;
    mul_op    = '0;
    case (state_r)
      svp_pkg::ST_IDLE: begin
        ram_we    = in_acc && (req == svp_pkg::REQ_LOAD) && (wr_ext < EW'(STORE_DEPTH));
        div_start = in_acc && (req == svp_pkg::REQ_STOP) && (in_fade_steps != '0);
      end
      svp_pkg::ST_RD1: begin
        mul_op.a = rng0_r ? s_ext : '0;
        mul_op.b = direct_r ? svp_pkg::MUL_B_W'(18'h10000)
                            : svp_pkg::MUL_B_W'(17'h10000 - {1'b0, frac_r});
      end
      svp_pkg::ST_MUL1: begin
        mul_op.a = (rng1_r && !direct_r) ? s_ext : '0;
        mul_op.b = svp_pkg::MUL_B_W'(frac_r);
      end
      svp_pkg::ST_MULG: begin
        mul_op.a = acc_r;
        mul_op.b = svp_pkg::MUL_B_W'(gain_r[31:16]);
      end
      svp_pkg::ST_MULM: begin
        mul_op.a = acc_r;
        mul_op.b = svp_pkg::MUL_B_W'(master_r);
      end
      default: begin
        mul_op = '0;
      end
    endcase
  end

  // State register, configuration, voice state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= svp_pkg::ST_IDLE;
      pitch_r      <= svp_pkg::PITCH_RST;
      start_gain_r <= svp_pkg::GAIN_RST;
      loop_r       <= 1'b0;
      frames_r     <= '0;
      master_r     <= svp_pkg::GAIN_RST;
      pos_r        <= '0;
      gain_r       <= '0;
      incr_r       <= '0;
      ramp_r       <= '0;
      fade_r       <= '0;
      playing_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes.
      if (cfg_valid && cfg_ready) begin
        case (svp_pkg::reg_idx_t'(cfg_index))
          svp_pkg::REG_PITCH_STEP:    pitch_r      <= cfg_data[svp_pkg::PITCH_W-1:0];
          svp_pkg::REG_START_GAIN:    start_gain_r <= cfg_data[svp_pkg::GAIN_W-1:0];
          svp_pkg::REG_LOOP_ENABLE:   loop_r       <= cfg_data[0];
          svp_pkg::REG_SAMPLE_FRAMES: frames_r     <= cfg_data[svp_pkg::FRAMES_W-1:0];
          svp_pkg::REG_MASTER_GAIN:   master_r     <= cfg_data[svp_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end

      // Start and stop items act on the voice when accepted.
      if (in_acc && (req == svp_pkg::REQ_START)) begin
        pos_r     <= '0;
        gain_r    <= {start_gain_r, 16'h0000};
        incr_r    <= '0;
        ramp_r    <= '0;
        fade_r    <= '0;
        playing_r <= 1'b1;
      end
      if (in_acc && (req == svp_pkg::REQ_STOP)) begin
        fade_r <= in_fade_steps;
        ramp_r <= in_fade_steps;
        if (in_fade_steps == '0) begin
          gain_r <= '0;
          incr_r <= '0;
        end
      end

      // Gain decrement from the divider.
      if ((state_r == svp_pkg::ST_DIV) && !div_busy) begin
        incr_r <= div_quo;
      end

      // End of a tick: gain ramp, position, fade counter and end of sample.
      if (state_r == svp_pkg::ST_FIN) begin
        if (fired_r && (ramp_r != '0)) begin
          ramp_r <= ramp_r - 1'b1;
          gain_r <= (ramp_r == svp_pkg::FADE_W'(1)) ? '0 : gain_r - incr_r;
        end
        if (fade_r != '0) begin
          fade_r <= fade_r - 1'b1;
        end
        if (go_on) begin
          pos_r <= newpos_r;
        end else if (loop_r && !forced) begin
          pos_r <= '0;
        end else begin
          if (fired_r) begin
            pos_r <= newpos_r;
          end
          playing_r <= 1'b0;
        end
      end

      // Output register valid.
      if ((state_r == svp_pkg::ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of a tick and the output payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r    <= '0;
      base_r   <= pos_r[31:16];
      frac_r   <= pos_r[15:0];
      direct_r <= direct_now;
      fired_r  <= fire_now;
      more_r   <= more_now;
      newpos_r <= newpos_now;
    end
    case (state_r)
      svp_pkg::ST_RD0:  rng0_r <= rd_in_range;
      svp_pkg::ST_RD1:  rng1_r <= rd_in_range;
      svp_pkg::ST_MUL1: acc_r  <= prod_r[AcW-1:0];
      svp_pkg::ST_SUM:  acc_r  <= acc_r + prod_r[AcW-1:0];
      svp_pkg::ST_RNDX: acc_r  <= sh16[AcW-1:0];
      svp_pkg::ST_FIN:  res_r  <= fired_r ? y_sat : '0;
      default: ;
    endcase
    if ((state_r == svp_pkg::ST_OUT) && out_free) begin
      audio_r  <= res_r;
      active_r <= playing_r;
    end
  end

  // Sample store.
  svp_ram #(
    .WIDTH (svp_pkg::SAMPLE_W),
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (in_sample_value),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // Shared multiplier.
  svp_mul u_mul (
    .clk    (clk),
    .op     (mul_op),
    .prod_r (prod_r)
  );

  // Fade step divider.
  svp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (gain_r),
    .divisor  (in_fade_steps),
    .busy     (div_busy),
    .quotient (div_quo)
  );

endmodule

[rtl/svp_checker.sv]
// Port-level checks for the sample voice player and their binding.
module svp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [svp_pkg::SAMPLE_W-1:0] out_audio_out,
  input logic                                out_voice_active
);

  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took a second item straight after the first");

  // A new result only appears when an item has been in work.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in work");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_audio_out)
                                  && $stable(out_voice_active)))
    else $error("stalled result changed");

  // A stalled input item is not withdrawn.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> in_valid)
    else $error("stalled input item withdrawn");

endmodule

bind sample_voice_player_core svp_checker u_svp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_audio_out    (out_audio_out),
  .out_voice_active (out_voice_active)
);

[bench/sample_voice_player_core_tb.sv]
// Self-checking testbench for the sample voice player core, with its own voice predictor.
module sample_voice_player_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int SWEEP_TICKS = 540;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    req_t                       kind;
    logic [INDEX_W-1:0]         index;
    logic signed [SAMPLE_W-1:0] value;
    logic [FADE_W-1:0]          fade;
  } voice_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] audio;
    logic                       active;
  } voice_out_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   in_req_type = REQ_LOAD;
  logic [INDEX_W-1:0]           in_sample_index = '0;
  logic signed [SAMPLE_W-1:0]   in_sample_value = '0;
  logic [FADE_W-1:0]            in_fade_steps = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]   out_audio_out;
  logic                         out_voice_active;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = REG_PITCH_STEP;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;

  sample_voice_player_core #(
    .STORE_DEPTH(65536)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_sample_index  (in_sample_index),
    .in_sample_value  (in_sample_value),
    .in_fade_steps    (in_fade_steps),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_audio_out    (out_audio_out),
    .out_voice_active (out_voice_active),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Items waiting to be sent and frames waiting to come back.
  voice_req_t pending_reqs[$];
  voice_out_t due_frames[$];

  // Handshake bookkeeping shared between the edge processes.
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  voice_req_t  tx_req;
  voice_req_t  seen_req;
  voice_out_t  want;

  // Predicted voice settings, at their reset values.
  logic [PITCH_W-1:0]  p_step = PITCH_RST;
  logic [GAIN_W-1:0]   p_start_gain = GAIN_RST;
  logic                p_loop = 1'b0;
  logic [FRAMES_W-1:0] p_frames = '0;
  logic [GAIN_W-1:0]   p_master = GAIN_RST;

  // Predicted voice state.
  logic [SAMPLE_W-1:0]  voice_store [0:65535];
  logic [POS_W-1:0]     v_pos = '0;
  logic [GAINACC_W-1:0] v_gain = '0;
  logic [GAINACC_W-1:0] v_gain_dec = '0;
  logic [FADE_W-1:0]    v_ramp = '0;
  logic [FADE_W:0]      v_fade = '0;
  logic                 v_on = 1'b0;

  task automatic note_mismatch(string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("mismatch: %s", msg);
    end
    mismatches++;
  endtask

  function automatic longint word_at(longint unsigned addr);
    if (addr > 65535) begin
      return 0;
    end
    return longint'($signed(voice_store[addr[15:0]]));
  endfunction

  // Adds half an output step and floors.
  function automatic longint round_down_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // One tick of a playing voice: read, interpolate, scale, advance, end checks.
  function automatic logic signed [SAMPLE_W-1:0] render_frame();
    longint unsigned span, pos, dmax, base;
    longint          frac, acc, x, y;
    bit              fired, more, forced;
    span = (p_frames > MAX_FRAMES) ? 64'd65536 : 64'(p_frames);
    pos = 64'(v_pos);
    fired = 1'b0;
    more = 1'b0;
    forced = 1'b0;
    acc = 0;
    y = 0;
    if (p_step == UNITY_STEP) begin
      // Whole-frame steps read the store directly.
      if ((pos >> 16) < span) begin
        acc = word_at(pos >> 16) * 65536;
        fired = 1'b1;
        pos += 65536;
        more = (pos >> 16) < span;
      end
    end else begin
      dmax = (span != 0) ? (span - 1) << 16 : 64'd0;
      if (pos < dmax) begin
        base = pos >> 16;
        frac = longint'(pos & 64'hFFFF);
        acc = word_at(base) * (65536 - frac) + word_at(base + 1) * frac;
        fired = 1'b1;
        pos += 64'(p_step);
        more = pos < dmax;
      end
    end
    v_pos = (pos > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pos[31:0];

    // Scale by the voice gain before its ramp moves, then by the master gain.
    if (fired) begin
      x = round_down_shift(acc * longint'(v_gain[31:16]), 16);
      y = round_down_shift(x * longint'(p_master), 28);
      if (y > 32767) begin
        y = 32767;
      end
      if (y < -32768) begin
        y = -32768;
      end
      if (v_ramp != 0) begin
        v_ramp--;
        v_gain = (v_ramp == 0) ? '0 : v_gain - v_gain_dec;
      end
    end

    // The last fade tick ends the voice even when looping.
    if (v_fade == 1) begin
      more = 1'b0;
      forced = 1'b1;
    end
    if (v_fade != 0) begin
      v_fade--;
    end
    if (!more) begin
      if (p_loop && !forced) begin
        v_pos = '0;
      end else begin
        v_on = 1'b0;
      end
    end
    return y[15:0];
  endfunction

  // Expected result of one accepted item.
  function automatic voice_out_t voice_step(voice_req_t r);
    voice_out_t o;
    o.audio = '0;
    case (r.kind)
      REQ_LOAD: begin
        voice_store[r.index] = r.value;
      end
      REQ_START: begin
        v_pos = '0;
        v_gain = {p_start_gain, 16'h0000};
        v_gain_dec = '0;
        v_ramp = '0;
        v_fade = '0;
        v_on = 1'b1;
      end
      REQ_TICK: begin
        if (v_on) begin
          o.audio = render_frame();
        end
      end
      default: begin
        // Stop: set up the fade, even on an idle voice.
        v_fade = {1'b0, r.fade};
        v_ramp = r.fade;
        if (r.fade == 0) begin
          v_gain = '0;
          v_gain_dec = '0;
        end else begin
          v_gain_dec = v_gain / r.fade;
        end
      end
    endcase
    o.active = v_on;
    return o;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return GAIN_RST;
      1: return '0;
      2: return '1;
      3: return 16'($urandom_range(16'h2000, 16'h8000));
      default: return 16'($urandom());
    endcase
  endfunction

  // Mostly ticks on a started voice, with starts, stops and loads mixed in.
  function automatic voice_req_t rand_req();
    voice_req_t  r;
    int unsigned roll;
    int unsigned sel;
    r.index = 16'($urandom());
    r.value = 16'($urandom());
    r.fade = 20'($urandom());
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      r.kind = REQ_START;
    end else if (roll < 14) begin
      r.kind = REQ_STOP;
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        r.fade = '0;
      end else if (sel > 2) begin
        r.fade = 20'($urandom_range(1, 40));
      end
    end else if (roll < 24) begin
      r.kind = REQ_LOAD;
    end else begin
      r.kind = REQ_TICK;
    end
    return r;
  endfunction

  task automatic queue_req(req_t k, logic [INDEX_W-1:0] idx, logic [SAMPLE_W-1:0] val,
                           logic [FADE_W-1:0] fade);
    pending_reqs.push_back('{kind: k, index: idx, value: val, fade: fade});
  endtask

  // Waits until every queued item has gone in and every result has come back.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (pending_reqs.size() != 0 || in_valid || due_frames.size() != 0);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      REG_PITCH_STEP:    p_step = val[PITCH_W-1:0];
      REG_START_GAIN:    p_start_gain = val[GAIN_W-1:0];
      REG_LOOP_ENABLE:   p_loop = val[0];
      REG_SAMPLE_FRAMES: p_frames = val[FRAMES_W-1:0];
      REG_MASTER_GAIN:   p_master = val[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setup(logic [PITCH_W-1:0] step, logic [GAIN_W-1:0] sgain, logic lp,
                             logic [FRAMES_W-1:0] frames, logic [GAIN_W-1:0] mgain);
    write_reg(REG_PITCH_STEP, step);
    write_reg(REG_START_GAIN, sgain);
    write_reg(REG_LOOP_ENABLE, lp);
    write_reg(REG_SAMPLE_FRAMES, frames);
    write_reg(REG_MASTER_GAIN, mgain);
  endtask

  // Clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Monitor: checks accepted results and predicts each accepted item.
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    out_fire <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (due_frames.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = due_frames.pop_front();
        if (out_audio_out !== want.audio) begin
          note_mismatch($sformatf("result %0d audio_out %0d, expected %0d",
                                  results_seen, out_audio_out, want.audio));
        end
        if (out_voice_active !== want.active) begin
          note_mismatch($sformatf("result %0d voice_active %b, expected %b",
                                  results_seen, out_voice_active, want.active));
        end
      end
      results_seen++;
    end
    if (rst_n && in_valid && !in_stall) begin
      seen_req.kind = req_t'(in_req_type);
      seen_req.index = in_sample_index;
      seen_req.value = in_sample_value;
      seen_req.fade = in_fade_steps;
      due_frames.push_back(voice_step(seen_req));
    end
  end

  // Driver: offers the next pending item after a drawn number of idle cycles.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait--;
      end else if (pending_reqs.size() != 0) begin
        tx_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_req_type <= tx_req.kind;
        in_sample_index <= tx_req.index;
        in_sample_value <= tx_req.value;
        in_fade_steps <= tx_req.fade;
        tx_wait = tx_idle ? $urandom_range(0, 6) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls a drawn number of cycles per item, or for a long hold-off.
  always @(negedge clk) begin
    if (out_fire) begin
      rx_wait = rx_idle ? $urandom_range(0, 6) : 0;
    end
    if (hold_asks != hold_served) begin
      hold_left = HOLD_CYCLES;
      hold_served++;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    logic [PITCH_W-1:0]  step;
    logic [FRAMES_W-1:0] frames;
    int                  ph;
    int                  k;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: an idle tick, a start over an empty sample, an idle stop
    // with the longest fade, and loads with the extreme values and addresses.
    queue_req(REQ_TICK, '0, '0, '0);
    queue_req(REQ_START, '0, '0, '0);
    queue_req(REQ_TICK, '0, '0, '0);
    queue_req(REQ_STOP, '0, '0, 20'hFFFFF);
    queue_req(REQ_LOAD, 16'd0, 16'sh7FFF, '0);
    queue_req(REQ_LOAD, 16'd1, 16'sh8000, '0);
    queue_req(REQ_LOAD, 16'd2, 16'sd0, '0);
    queue_req(REQ_LOAD, 16'd3, -16'sd1, '0);
    queue_req(REQ_LOAD, 16'd4, 16'sd1, '0);
    queue_req(REQ_LOAD, 16'd5, 16'sd12345, '0);
    queue_req(REQ_LOAD, 16'd6, -16'sd23456, '0);
    queue_req(REQ_LOAD, 16'hFFFF, 16'sh8000, '0);
    drain();

    // Direct reads: a fade that ends the voice, a zero fade, restarts.
    apply_setup(UNITY_STEP, GAIN_RST, 1'b0, 17'd7, GAIN_RST);
    queue_req(REQ_START, '0, '0, '0);
    queue_req(REQ_TICK, '0, '0, '0);
    queue_req(REQ_TICK, '0, '0, '0);
    queue_req(REQ_STOP, '0, '0, 20'd2);
    queue_req(REQ_TICK, '0, '0, '0);
    queue_req(REQ_TICK, '0, '0, '0);
    queue_req(REQ_TICK, '0, '0, '0);
    queue_req(REQ_START, '0, '0, '0);
    queue_req(REQ_STOP, '0, '0, 20'd0);
    queue_req(REQ_TICK, '0, '0, '0);
    queue_req(REQ_START, '0, '0, '0);
    drain();

    // Half steps with the largest gains drive the output into saturation.
    apply_setup(24'h008000, 16'hFFFF, 1'b1, 17'd7, 16'hFFFF);
    queue_req(REQ_START, '0, '0, '0);
    queue_req(REQ_TICK, '0, '0, '0);
    queue_req(REQ_TICK, '0, '0, '0);
    queue_req(REQ_TICK, '0, '0, '0);
    drain();

    // Fill the whole store so that any frame count reads written words only.
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (k = 0; k < 65536; k++) begin
      queue_req(REQ_LOAD, 16'(k), 16'($urandom()), 20'($urandom()));
    end
    drain();

    // Random phases, each under its own settings.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (ph == 0) begin
        apply_setup('0, '0, 1'b0, '0, '0);
      end else if (ph == 1) begin
        apply_setup('1, '1, 1'b1, '1, '1);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: step = UNITY_STEP;
          3:       step = '0;
          4:       step = '1;
          5:       step = 24'($urandom());
          default: step = 24'($urandom_range(1, 24'h30000));
        endcase
        case ($urandom_range(0, 9))
          0:       frames = 17'($urandom_range(0, 1));
          1:       frames = MAX_FRAMES;
          2:       frames = 17'($urandom_range(17'h10001, 17'h1FFFF));
          3:       frames = 17'($urandom());
          default: frames = 17'($urandom_range(2, 48));
        endcase
        apply_setup(step, pick_gain(), 1'($urandom()), frames, pick_gain());
      end
      // The receiver holds off while the sender keeps offering items.
      if (ph == 4 || ph == 9) begin
        hold_asks++;
      end
      queue_req(REQ_START, 16'($urandom()), 16'($urandom()), 20'($urandom()));
      for (k = 1; k < PHASE_ITEMS; k++) begin
        pending_reqs.push_back(rand_req());
      end
      drain();
    end

    // Coarse steps over the full store run the position into saturation.
    tx_idle = ($urandom_range(0, 1) != 0);
    rx_idle = ($urandom_range(0, 1) != 0);
    frames = ($urandom_range(0, 1) != 0) ? MAX_FRAMES :
             17'($urandom_range(17'h10001, 17'h1FFFF));
    apply_setup(24'h7F0000 + 24'($urandom_range(0, 16'hFFFF)), pick_gain(), 1'($urandom()),
                frames, pick_gain());
    queue_req(REQ_START, '0, '0, '0);
    for (k = 0; k < SWEEP_TICKS; k++) begin
      queue_req(REQ_TICK, 16'($urandom()), 16'($urandom()), 20'($urandom()));
    end
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_frames.size() != 0) begin
      note_mismatch($sformatf("%0d expected results never came", due_frames.size()));
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/svp_pkg.sv
rtl/svp_ram.sv
rtl/svp_mul.sv
rtl/svp_div.sv
rtl/sample_voice_player_core.sv
rtl/svp_checker.sv
bench/sample_voice_player_core_tb.sv
